FILE: rtl/elm_pkg.sv
// ----------------------------------------------------------------------------
// elm_pkg
// Shared constants and helpers for the ethernet link monitor: state codes,
// PHY status bit positions, register map and gap values.
// ----------------------------------------------------------------------------
package elm_pkg;

  // link supervision state codes
  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_WAIT   = 3'd1;
  localparam logic [2:0] ST_DELAY  = 3'd2;
  localparam logic [2:0] ST_LINKED = 3'd3;
  localparam logic [2:0] ST_REST   = 3'd4;

  // basic status word bits
  localparam int unsigned BS_LINK     = 2;
  localparam int unsigned BS_CAP_ANEG = 3;
  localparam int unsigned BS_ANEG_ACK = 5;

  // special status word bits
  localparam int unsigned SP_100      = 3;
  localparam int unsigned SP_FDX      = 4;
  localparam int unsigned SP_AUTODONE = 12;

  // inter-packet gap values
  localparam logic [4:0] GAP_FULL = 5'd21;
  localparam logic [4:0] GAP_HALF = 5'd18;

  // configuration register map (index is paddr bit 2)
  localparam logic REG_LINK_UP_DELAY = 1'b0;
  localparam logic REG_REST_CHECK    = 1'b1;

  localparam logic [15:0] LINK_UP_DELAY_RST = 16'd1000;
  localparam logic [15:0] REST_CHECK_RST    = 16'd10;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // wrapping time difference compared against a 16-bit limit
  function automatic logic elapsed(input logic [31:0] now, input logic [31:0] mark,
                                   input logic [15:0] limit);
    logic [31:0] diff;
    diff = now - mark;
    return diff >= {16'd0, limit};
  endfunction

endpackage

FILE: rtl/elm_in_if.sv
// ----------------------------------------------------------------------------
// elm_in_if
// Poll / start channel into the link monitor, valid-ready handshake.
// ----------------------------------------------------------------------------
interface elm_in_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic [31:0] now_ms;
  logic        status_ok;
  logic [15:0] basic_word;
  logic        special_ok;
  logic [15:0] special_word;

  modport source (
    output valid, start_req, now_ms, status_ok, basic_word, special_ok, special_word,
    input  ready
  );
  modport sink (
    input  valid, start_req, now_ms, status_ok, basic_word, special_ok, special_word,
    output ready
  );
endinterface

FILE: rtl/elm_out_if.sv
// ----------------------------------------------------------------------------
// elm_out_if
// Link status result channel out of the link monitor, valid-ready handshake.
// ----------------------------------------------------------------------------
interface elm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] link_state;
  logic       link_ok;
  logic       linked;
  logic       rate_100m;
  logic       duplex_full;
  logic [4:0] gap_value;
  logic       settings_update;
  logic       rx_enable_set;

  modport source (
    output valid, link_state, link_ok, linked, rate_100m, duplex_full, gap_value,
           settings_update, rx_enable_set,
    input  ready
  );
  modport sink (
    input  valid, link_state, link_ok, linked, rate_100m, duplex_full, gap_value,
           settings_update, rx_enable_set,
    output ready
  );
endinterface

FILE: rtl/ethernet_link_monitor_unit.sv
// ----------------------------------------------------------------------------
// ethernet_link_monitor_unit
// PHY link supervision: judges link from polled status words, latches speed
// and duplex on link rise, and walks a five-state link state machine.
// ----------------------------------------------------------------------------
// result: a result beat is valid the cycle after its input beat is accepted
// throughput: one beat per cycle; the single result register keeps accepting
//   while the sink takes each beat, and stalls input only while it holds a
//   beat that the sink does not take
// reset (synchronous, rst_n low): state init, latches cleared, delay 1000 ms,
//   rest check 10 ms, no result pending
module ethernet_link_monitor_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  elm_in_if.sink                        in_ch,
  elm_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [elm_pkg::ADDR_W-1:0]    paddr,
  input  logic [elm_pkg::DATA_W-1:0]    pwdata,
  output logic [elm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  // configuration registers
  logic [15:0] link_up_delay_r;
  logic [15:0] rest_check_r;
  logic        cfg_wr;

  // link state
  logic [2:0]  state_r,  state_nxt;
  logic        prev_up_r, prev_up_nxt;
  logic [31:0] mark_r,   mark_nxt;
  logic        speed_r,  speed_nxt;
  logic        duplex_r, duplex_nxt;

  // result register
  logic        out_valid_r;
  logic [2:0]  res_state_r;
  logic        res_up_r, res_upd_r, res_rxen_r;

  logic        in_acc;
  logic        up, upd, rxen, an_done;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_up_delay_r <= elm_pkg::LINK_UP_DELAY_RST;
      rest_check_r    <= elm_pkg::REST_CHECK_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        elm_pkg::REG_LINK_UP_DELAY: link_up_delay_r <= pwdata[15:0];
        elm_pkg::REG_REST_CHECK:    rest_check_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (paddr[2])
      elm_pkg::REG_LINK_UP_DELAY: prdata = {16'd0, link_up_delay_r};
      elm_pkg::REG_REST_CHECK:    prdata = {16'd0, rest_check_r};
      default:                    prdata = '0;
    endcase
  end

  // handshake: take a beat whenever the result register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // link judgement and next state
  always_comb begin
    state_nxt   = state_r;
    prev_up_nxt = prev_up_r;
    mark_nxt    = mark_r;
    speed_nxt   = speed_r;
    duplex_nxt  = duplex_r;
    up          = 1'b0;
    upd         = 1'b0;
    rxen        = 1'b0;
    an_done     = in_ch.special_ok && in_ch.special_word[elm_pkg::SP_AUTODONE];
    if (in_ch.start_req) begin
      state_nxt   = elm_pkg::ST_WAIT;
      prev_up_nxt = 1'b0;
      speed_nxt   = 1'b0;
      duplex_nxt  = 1'b0;
    end else begin
      up = in_ch.status_ok && in_ch.basic_word[elm_pkg::BS_LINK]
           && in_ch.basic_word[elm_pkg::BS_CAP_ANEG]
           && in_ch.basic_word[elm_pkg::BS_ANEG_ACK];
      // latch speed and duplex on link rise
      if (up && !prev_up_r) begin
        speed_nxt  = an_done && in_ch.special_word[elm_pkg::SP_100];
        duplex_nxt = an_done && in_ch.special_word[elm_pkg::SP_FDX];
        upd        = 1'b1;
      end
      prev_up_nxt = up;
      unique case (state_r)
        elm_pkg::ST_INIT: ;
        elm_pkg::ST_WAIT: begin
          if (up) begin
            mark_nxt  = in_ch.now_ms;
            state_nxt = elm_pkg::ST_DELAY;
          end
        end
        elm_pkg::ST_DELAY: begin
          if (!up) begin
            state_nxt = elm_pkg::ST_WAIT;
          end else if (elm_pkg::elapsed(in_ch.now_ms, mark_r, link_up_delay_r)) begin
            state_nxt = elm_pkg::ST_LINKED;
            rxen      = 1'b1;
          end
        end
        elm_pkg::ST_REST: begin
          if (elm_pkg::elapsed(in_ch.now_ms, mark_r, rest_check_r)) begin
            if (up) begin
              state_nxt = elm_pkg::ST_LINKED;
            end else begin
              mark_nxt = in_ch.now_ms;
            end
          end
        end
        default: begin
          // linked, and any unused code
          state_nxt = elm_pkg::ST_LINKED;
          if (!up) begin
            state_nxt = elm_pkg::ST_REST;
            mark_nxt  = in_ch.now_ms;
          end
        end
      endcase
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= elm_pkg::ST_INIT;
      prev_up_r <= 1'b0;
      mark_r    <= '0;
      speed_r   <= 1'b0;
      duplex_r  <= 1'b0;
    end else if (in_acc) begin
      state_r   <= state_nxt;
      prev_up_r <= prev_up_nxt;
      mark_r    <= mark_nxt;
      speed_r   <= speed_nxt;
      duplex_r  <= duplex_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_state_r <= state_nxt;
      res_up_r    <= up;
      res_upd_r   <= upd;
      res_rxen_r  <= rxen;
    end
  end

  // speed and duplex come straight from the latches, which only move on accept
  assign out_ch.valid           = out_valid_r;
  assign out_ch.link_state      = res_state_r;
  assign out_ch.link_ok         = res_up_r;
  assign out_ch.linked          = (res_state_r == elm_pkg::ST_LINKED);
  assign out_ch.rate_100m       = speed_r;
  assign out_ch.duplex_full     = duplex_r;
  assign out_ch.gap_value       = duplex_r ? elm_pkg::GAP_FULL : elm_pkg::GAP_HALF;
  assign out_ch.settings_update = res_upd_r;
  assign out_ch.rx_enable_set   = res_rxen_r;

  // receive enable only on entering linked
  a_rxen_linked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_rxen_r |-> res_state_r == elm_pkg::ST_LINKED)
    else $error("rx enable without linked state");

  // settings latch only when the link is judged up
  a_upd_up: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_upd_r |-> res_up_r)
    else $error("settings update while link down");

  // an accepted beat always yields a pending result
  a_acc_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted beat produced no result");

  // a start beat clears the latches and lands in wait link
  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.start_req |=> state_r == elm_pkg::ST_WAIT && !speed_r && !duplex_r)
    else $error("start beat did not reset link state");

  // rest state can only be reached from linked or from an unused state code
  a_rest_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && state_nxt == elm_pkg::ST_REST && state_r != elm_pkg::ST_REST
      |-> state_r == elm_pkg::ST_LINKED || state_r > elm_pkg::ST_REST)
    else $error("rest entered from wrong state");

endmodule
